FILE: hw/rtl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg: shared types and constants for the k-means pixel cluster pass
// Field structs, cell control and best-match records, FSM state codes.
// ----------------------------------------------------------------------------
`default_nettype none
package kpc_pkg;

	localparam int NCELL   = 8;
	localparam int IDX_W   = 3;
	localparam int K_W     = 4;
	localparam int NC_W    = 3;
	localparam int NCH     = 4;
	localparam int SUM_W   = 24;
	localparam int CNT_W   = 17;
	localparam int DIST_W  = 18;
	localparam int PIX_AW  = 16;
	localparam int POS_W   = PIX_AW + 1;
	localparam int MAX_PIXELS = 1 << PIX_AW;
	localparam int DVD_W   = SUM_W + 1;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_PIXEL = 2'd1,
		KIND_END   = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIST,
		S_PXOUT,
		S_MGO,
		S_MWAIT,
		S_EMIT
	} state_t;

	typedef logic [NCH-1:0][7:0] chan_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] centroid_slot;
		logic [7:0] chan_red;
		logic [7:0] chan_green;
		logic [7:0] chan_blue;
		logic [7:0] chan_alpha;
	} in_t;

	typedef struct packed {
		logic [2:0] out_cluster;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       converged;
		logic       overflow;
		logic       last;
	} out_t;

	typedef struct packed {
		logic             load;
		logic [IDX_W-1:0] slot;
		logic             acc;
		logic [IDX_W-1:0] sel;
		logic             clr;
		logic             mean_go;
		logic [K_W-1:0]   k;
		logic [NC_W-1:0]  nc;
	} cell_ctl_t;

	typedef struct packed {
		logic              vld;
		logic [DIST_W-1:0] sqd;
		logic [IDX_W-1:0]  idx;
	} best_t;

endpackage
`default_nettype wire

FILE: hw/rtl/kpc_div.sv
// ----------------------------------------------------------------------------
// kpc_div: restoring divider
// One quotient bit per cycle; done pulses with the quotient ready.
// ----------------------------------------------------------------------------
`default_nettype none
module kpc_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [kpc_pkg::DVD_W-1:0] dividend,
	input  wire logic [kpc_pkg::CNT_W-1:0] divisor,
	output logic [kpc_pkg::DVD_W-1:0]      quotient,
	output logic                           done
);
	import kpc_pkg::*;

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [CNT_W:0]    trial;
	logic              ge;

	// shift in next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign quotient = quo_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/kpc_cell.sv
// ----------------------------------------------------------------------------
// kpc_cell: one cluster cell
// Holds a centroid, its channel sums and member count. Compares its distance
// to the best match handed in from the left neighbor and registers the winner.
// ----------------------------------------------------------------------------
`default_nettype none
module kpc_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [kpc_pkg::IDX_W-1:0] cell_idx,
	input  wire kpc_pkg::cell_ctl_t        ctl,
	input  wire kpc_pkg::chan_t            pix,
	input  wire kpc_pkg::best_t            best_in,
	output kpc_pkg::best_t                 best_out,
	output kpc_pkg::chan_t                 cent,
	output logic                           busy
);
	import kpc_pkg::*;

	chan_t                      cent_q;
	logic [NCH-1:0][SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]           cnt_q;
	best_t                      best_q;
	logic                       mbusy_q;
	logic [1:0]                 mch_q;
	logic                       dgo_q;
	logic                       part;
	logic [DIST_W-1:0]          sqd;
	logic [DVD_W-1:0]           dvd;
	logic [DVD_W-1:0]           quo;
	logic                       ddone;
	logic                       last_ch;

	assign part     = {1'b0, cell_idx} < ctl.k;
	assign best_out = best_q;
	assign cent     = cent_q;
	assign busy     = mbusy_q;

	// squared distance over channels in use
	always_comb begin
		logic [7:0]  ad;
		logic [15:0] sq;
		sqd = '0;
		for (int c = 0; c < NCH; c++) begin
			ad = (pix[c] > cent_q[c]) ? pix[c] - cent_q[c] : cent_q[c] - pix[c];
			sq = ad * ad;
			if (NC_W'(c) < ctl.nc)
				sqd = sqd + DIST_W'(sq);
		end
	end

	// best-match stage, ties keep the lower index from the left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (part && (!best_in.vld || sqd < best_in.sqd)) begin
			best_q <= '{vld: 1'b1, sqd: sqd, idx: cell_idx};
		end else begin
			best_q <= best_in;
		end
	end

	// mean update divider, channels one after another
	assign dvd     = {1'b0, sum_q[mch_q]} + DVD_W'(cnt_q >> 1);
	assign last_ch = ({1'b0, mch_q} + 3'd1) >= ctl.nc;

	kpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dgo_q),
		.dividend (dvd),
		.divisor  (cnt_q),
		.quotient (quo),
		.done     (ddone)
	);

	// mean sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mch_q   <= '0;
			dgo_q   <= 1'b0;
		end else begin
			dgo_q <= 1'b0;
			if (ctl.mean_go && part && cnt_q != '0) begin
				mbusy_q <= 1'b1;
				mch_q   <= '0;
				dgo_q   <= 1'b1;
			end else if (ddone) begin
				if (last_ch) begin
					mbusy_q <= 1'b0;
				end else begin
					mch_q <= mch_q + 1'b1;
					dgo_q <= 1'b1;
				end
			end
		end
	end

	// centroid, sums and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cent_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctl.load && ctl.slot == cell_idx)
				cent_q <= pix;
			if (ddone)
				cent_q[mch_q] <= (quo > DVD_W'(255)) ? 8'hFF : quo[7:0];
			if (ctl.clr) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else if (ctl.acc && ctl.sel == cell_idx) begin
				for (int c = 0; c < NCH; c++) begin
					if (NC_W'(c) < ctl.nc) begin
						if (({1'b0, sum_q[c]} + (SUM_W+1)'(pix[c])) > (SUM_W+1)'({SUM_W{1'b1}}))
							sum_q[c] <= {SUM_W{1'b1}};
						else
							sum_q[c] <= sum_q[c] + SUM_W'(pix[c]);
					end
				end
				if (cnt_q != {CNT_W{1'b1}})
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/kmeans_pixel_cluster_pass_core.sv
// ----------------------------------------------------------------------------
// kmeans_pixel_cluster_pass_core: one k-means pass over a pixel stream
// Cluster cells in a row pass the best match rightward; a sequencer drives
// loads, accumulation, mean updates and the end-of-pass centroid dump.
//
//  channel   signals                     transfer when
//  input     in_valid/in_stall/in_data   in_valid && !in_stall
//  output    out_valid/out_stall/out_data out_valid && !out_stall
//  config    cfg_we/cfg_index/cfg_data   cfg_we
//
// Load: written into its cell as the item is accepted. Pixel: waits while
// the best match passes the 8-cell match row. End of pass: one centroid out
// per cycle unless stalled, after a mean update per channel when unconverged.
// Reset clears control state; previous assignments read as zero until written.
// Output stalls hold the sequencer; input is stalled while an item is at work.
// ----------------------------------------------------------------------------
`default_nettype none
module kmeans_pixel_cluster_pass_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire kpc_pkg::in_t in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output kpc_pkg::out_t    out_data,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data
);
	import kpc_pkg::*;

	localparam int WAIT_W = $clog2(NCELL + 1);

	state_t                  state_q, state_d;
	logic [K_W-1:0]          ncl_q;
	logic [NC_W-1:0]         nch_q;
	logic [K_W-1:0]          k_sat;
	logic [NC_W-1:0]         nc_sat;
	chan_t                   pix_q;
	logic [WAIT_W-1:0]       wait_q;
	logic [POS_W-1:0]        pos_q;
	logic [POS_W-1:0]        fill_q;
	logic                    changed_q;
	logic                    conv_q;
	logic                    ovf_q;
	logic [IDX_W-1:0]        eidx_q;
	logic [2:0]              prev_mem [MAX_PIXELS];
	logic [2:0]              prev_rd_q;
	logic [2:0]              prev_val;
	logic                    in_xfer;
	logic                    out_free;
	logic                    out_load;
	out_t                    out_d;
	cell_ctl_t               ctl;
	best_t                   chain [NCELL+1];
	chan_t                   cents [NCELL];
	logic [NCELL-1:0]        busys;
	best_t                   best;
	logic                    emit_last;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_free = !out_valid || !out_stall;
	assign best     = chain[NCELL];
	assign prev_val = (pos_q < fill_q) ? prev_rd_q : 3'd0;
	assign emit_last = ({1'b0, eidx_q} + 4'd1) == k_sat;

	// saturated register values
	always_comb begin
		k_sat = ncl_q;
		if (ncl_q == '0) k_sat = K_W'(1);
		else if (ncl_q > K_W'(NCELL)) k_sat = K_W'(NCELL);
		nc_sat = nch_q;
		if (nch_q == '0) nc_sat = NC_W'(1);
		else if (nch_q > NC_W'(NCH)) nc_sat = NC_W'(NCH);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncl_q <= K_W'(8);
			nch_q <= NC_W'(4);
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) ncl_q <= cfg_data;
			else nch_q <= cfg_data[NC_W-1:0];
		end
	end

	// next state, cell control and output load
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ctl.k    = k_sat;
		ctl.nc   = nc_sat;
		ctl.slot = in_data.centroid_slot;
		ctl.sel  = best.idx;
		out_load = 1'b0;
		out_d    = '0;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (kind_t'(in_data.kind))
						KIND_LOAD:  ctl.load = 1'b1;
						KIND_PIXEL: state_d = (pos_q >= POS_W'(MAX_PIXELS)) ? S_PXOUT : S_DIST;
						KIND_END:   state_d = changed_q ? S_MGO : S_EMIT;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_DIST: begin
				if (wait_q == WAIT_W'(NCELL - 1)) state_d = S_PXOUT;
			end
			S_PXOUT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d.overflow = ovf_q;
					if (!ovf_q) begin
						out_d.out_cluster = best.idx;
						ctl.acc = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_MGO: begin
				ctl.mean_go = 1'b1;
				state_d = S_MWAIT;
			end
			S_MWAIT: begin
				if (busys == '0) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d.out_cluster = eidx_q;
					out_d.out_red     = cents[eidx_q][0];
					out_d.out_green   = cents[eidx_q][1];
					out_d.out_blue    = cents[eidx_q][2];
					out_d.out_alpha   = cents[eidx_q][3];
					out_d.converged   = conv_q;
					out_d.last        = emit_last;
					if (emit_last) begin
						ctl.clr = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and pass bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wait_q    <= '0;
			pos_q     <= '0;
			fill_q    <= '0;
			changed_q <= 1'b0;
			conv_q    <= 1'b0;
			ovf_q     <= 1'b0;
			eidx_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIST) wait_q <= wait_q + 1'b1;
			else wait_q <= '0;
			if (in_xfer) begin
				ovf_q  <= pos_q >= POS_W'(MAX_PIXELS);
				conv_q <= !changed_q;
				eidx_q <= '0;
			end
			if (ctl.acc) begin
				if (prev_val != best.idx) changed_q <= 1'b1;
				pos_q <= pos_q + 1'b1;
				if (pos_q >= fill_q) fill_q <= pos_q + 1'b1;
			end
			if (state_q == S_EMIT && out_free) begin
				eidx_q <= eidx_q + 1'b1;
				if (emit_last) begin
					pos_q     <= '0;
					changed_q <= 1'b0;
				end
			end
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer)
			pix_q <= {in_data.chan_alpha, in_data.chan_blue,
				in_data.chan_green, in_data.chan_red};
		if (out_load) out_data <= out_d;
	end

	// previous assignment memory
	always_ff @(posedge clk) begin
		prev_rd_q <= prev_mem[pos_q[PIX_AW-1:0]];
		if (ctl.acc) prev_mem[pos_q[PIX_AW-1:0]] <= best.idx;
	end

	// row of cluster cells
	assign chain[0] = '0;
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		kpc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.ctl      (ctl),
			.pix      (ctl.load ? chan_t'({in_data.chan_alpha, in_data.chan_blue,
				in_data.chan_green, in_data.chan_red}) : pix_q),
			.best_in  (chain[i]),
			.best_out (chain[i+1]),
			.cent     (cents[i]),
			.busy     (busys[i])
		);
	end

`ifndef SYNTHESIS
	a_fill: assert property (@(posedge clk) disable iff (!arst_n) pos_q <= fill_q)
		else $error("position past fill count");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_PIXELS))
		else $error("position past capacity");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> busys == '0)
		else $error("mean update running while idle");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.overflow && out_data.last))
		else $error("overflow and last together");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the k-means pixel cluster pass core
// A queue-fed driver sends load, pixel, end-of-pass and ignored items with
// random gaps. A local copy of the clustering state predicts every result, and
// a monitor checks each output transfer against the oldest expected result.
// Register settings change between phases while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kpc_pkg::*;

	localparam int WDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t  in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [3:0] cfg_data = '0;

	kmeans_pixel_cluster_pass_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predicted clustering state
	logic [7:0]  cent [8][4];
	int unsigned sums [8][4];
	int unsigned cnts [8];
	logic [2:0]  prev_cluster [MAX_PIXELS];
	int unsigned pix_pos;
	bit          moved;
	logic [3:0]  k_reg = 4'd8;
	logic [3:0]  nc_reg = 4'd4;

	in_t  pending_items [$];
	out_t expected_results [$];
	bit   quiet = 1'b0;
	int   mismatches = 0;
	int   n_results = 0;
	int   n_items = 0;
	int   n_overflow = 0;
	int   n_conv = 0;

	function automatic int unsigned k_active();
		if (k_reg < 1) return 1;
		if (k_reg > 8) return 8;
		return k_reg;
	endfunction

	function automatic int unsigned nc_active();
		if (nc_reg < 1) return 1;
		if (nc_reg > 4) return 4;
		return nc_reg;
	endfunction

	// Work out the results one accepted item causes and update the state
	function automatic void cluster_step(in_t it);
		logic [7:0] px [4];
		out_t e;
		int unsigned kk, nn, best, best_d, d, m, s;
		int diff;
		kk = k_active();
		nn = nc_active();
		px[0] = it.chan_red; px[1] = it.chan_green;
		px[2] = it.chan_blue; px[3] = it.chan_alpha;
		e = '0;
		case (kind_t'(it.kind))
			KIND_LOAD: begin
				for (int ch = 0; ch < 4; ch++) cent[it.centroid_slot][ch] = px[ch];
			end
			KIND_PIXEL: begin
				if (pix_pos >= MAX_PIXELS) begin
					e.overflow = 1'b1;
					expected_results.push_back(e);
					return;
				end
				best = 0;
				best_d = 0;
				for (int c = 0; c < kk; c++) begin
					d = 0;
					for (int ch = 0; ch < nn; ch++) begin
						diff = int'(px[ch]) - int'(cent[c][ch]);
						d += diff * diff;
					end
					if (c == 0 || d < best_d) begin
						best_d = d;
						best = c;
					end
				end
				if (prev_cluster[pix_pos] != best[2:0]) moved = 1'b1;
				prev_cluster[pix_pos] = best[2:0];
				pix_pos++;
				for (int ch = 0; ch < nn; ch++) begin
					s = sums[best][ch] + px[ch];
					sums[best][ch] = (s > 24'hFFFFFF) ? 24'hFFFFFF : s;
				end
				if (cnts[best] < 17'h1FFFF) cnts[best]++;
				e.out_cluster = best[2:0];
				expected_results.push_back(e);
			end
			KIND_END: begin
				if (moved) begin
					for (int c = 0; c < kk; c++) begin
						if (cnts[c] != 0) begin
							for (int ch = 0; ch < nn; ch++) begin
								m = (sums[c][ch] + cnts[c] / 2) / cnts[c];
								cent[c][ch] = (m > 255) ? 8'd255 : m[7:0];
							end
						end
					end
				end
				for (int c = 0; c < kk; c++) begin
					e = '0;
					e.out_cluster = c[2:0];
					e.out_red = cent[c][0];
					e.out_green = cent[c][1];
					e.out_blue = cent[c][2];
					e.out_alpha = cent[c][3];
					e.converged = !moved;
					e.last = (c + 1 == kk);
					expected_results.push_back(e);
				end
				for (int c = 0; c < 8; c++) begin
					cnts[c] = 0;
					for (int ch = 0; ch < 4; ch++) sums[c][ch] = 0;
				end
				pix_pos = 0;
				moved = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function automatic in_t mk(kind_t kd, int slot, int r, int g, int b, int a);
		in_t it;
		it.kind = kd;
		it.centroid_slot = slot[2:0];
		it.chan_red = r[7:0];
		it.chan_green = g[7:0];
		it.chan_blue = b[7:0];
		it.chan_alpha = a[7:0];
		return it;
	endfunction

	function automatic int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Input driver: one nonblocking write of in_valid per edge
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				cluster_step(in_data);
				n_items++;
				in_gap = gap_len();
			end
			if (in_valid && in_stall) begin
				in_valid <= 1'b1;
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output stall pattern
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!quiet) stall_left = gap_len();
		end
	end

	// Result monitor
	always @(posedge clk) begin
		out_t e;
		bit bad;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (out_data.overflow) n_overflow++;
			if (out_data.converged && out_data.last) n_conv++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %p", out_data);
			end else begin
				e = expected_results.pop_front();
				bad = (e.out_cluster != out_data.out_cluster) ||
					(e.out_red != out_data.out_red) ||
					(e.out_green != out_data.out_green) ||
					(e.out_blue != out_data.out_blue) ||
					(e.out_alpha != out_data.out_alpha) ||
					(e.converged != out_data.converged) ||
					(e.overflow != out_data.overflow) ||
					(e.last != out_data.last);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: expected %p got %p", e, out_data);
				end
			end
		end
	end

	// Watchdog: cycles without any transfer while work is outstanding
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(pending_items.size() == 0 && expected_results.size() == 0 && !in_valid))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", WDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(bit idx, logic [3:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx) nc_reg = val & 4'h7;
		else k_reg = val;
	endtask

	function automatic int clamp8(int v);
		return (v < 0) ? 0 : (v > 255) ? 255 : v;
	endfunction

	// Random phase: seed centroids, then replay one pixel set over a few passes
	task automatic random_phase(int npix);
		in_t pix [$];
		int c, passes, r;
		int kk;
		kk = k_active();
		for (int i = 0; i < kk; i++)
			pending_items.push_back(mk(KIND_LOAD, i, $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)));
		for (int i = 0; i < npix; i++) begin
			c = $urandom_range(0, kk - 1);
			r = $urandom_range(0, 9);
			if (r < 7)
				pix.push_back(mk(KIND_PIXEL, 0,
					clamp8(int'($urandom_range(0, 255)) % 64 + c * 32),
					clamp8(int'($urandom_range(0, 40)) + c * 30),
					clamp8(255 - c * 30 - int'($urandom_range(0, 40))),
					$urandom_range(0, 255)));
			else
				pix.push_back(mk(KIND_PIXEL, $urandom_range(0, 7), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)));
		end
		passes = $urandom_range(2, 3);
		for (int p = 0; p < passes; p++) begin
			foreach (pix[i]) begin
				if ($urandom_range(0, 30) == 0)
					pending_items.push_back(mk(KIND_NONE, $urandom_range(0, 7),
						$urandom_range(0, 255), 0, 0, 0));
				pending_items.push_back(pix[i]);
			end
			pending_items.push_back(mk(KIND_END, 0, 0, 0, 0, 0));
		end
		drain();
	endtask

	initial begin
		for (int c = 0; c < 8; c++) begin
			cnts[c] = 0;
			for (int ch = 0; ch < 4; ch++) begin
				cent[c][ch] = '0;
				sums[c][ch] = 0;
			end
		end
		foreach (prev_cluster[i]) prev_cluster[i] = '0;
		pix_pos = 0;
		moved = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All centroids zero after reset: every pixel ties into cluster 0
		pending_items.push_back(mk(KIND_PIXEL, 0, 255, 255, 255, 255));
		pending_items.push_back(mk(KIND_PIXEL, 7, 0, 0, 0, 0));
		pending_items.push_back(mk(KIND_END, 0, 0, 0, 0, 0));
		// Extremes, equal centroids (tie to lower index), ignored kind
		pending_items.push_back(mk(KIND_LOAD, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(KIND_LOAD, 1, 255, 255, 255, 255));
		pending_items.push_back(mk(KIND_LOAD, 2, 100, 100, 100, 100));
		pending_items.push_back(mk(KIND_LOAD, 3, 100, 100, 100, 100));
		pending_items.push_back(mk(KIND_LOAD, 4, 255, 0, 255, 0));
		pending_items.push_back(mk(KIND_LOAD, 5, 0, 255, 0, 255));
		pending_items.push_back(mk(KIND_LOAD, 6, 170, 85, 170, 85));
		pending_items.push_back(mk(KIND_LOAD, 7, 85, 170, 85, 170));
		pending_items.push_back(mk(KIND_NONE, 5, 1, 2, 3, 4));
		pending_items.push_back(mk(KIND_PIXEL, 0, 255, 255, 255, 255));
		pending_items.push_back(mk(KIND_PIXEL, 0, 100, 100, 100, 100));
		pending_items.push_back(mk(KIND_PIXEL, 0, 101, 100, 100, 100));
		pending_items.push_back(mk(KIND_PIXEL, 0, 50, 50, 50, 50));
		pending_items.push_back(mk(KIND_PIXEL, 0, 254, 1, 254, 0));
		pending_items.push_back(mk(KIND_PIXEL, 0, 255, 0, 255, 1));
		pending_items.push_back(mk(KIND_PIXEL, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(KIND_END, 0, 0, 0, 0, 0));
		// Pass with no pixels right after: converged, centroids unchanged
		pending_items.push_back(mk(KIND_END, 0, 0, 0, 0, 0));
		drain();

		random_phase(8);
		write_reg(1'b0, 4'd1);
		write_reg(1'b1, 4'd1);
		random_phase(6);
		write_reg(1'b0, 4'd15);
		write_reg(1'b1, 4'd7);
		random_phase(10);
		write_reg(1'b0, 4'd0);
		write_reg(1'b1, 4'd8);
		random_phase(4);
		write_reg(1'b0, 4'd3);
		write_reg(1'b1, 4'd2);
		random_phase(8);
		write_reg(1'b0, 4'd8);
		write_reg(1'b1, 4'd3);
		random_phase(6);
		write_reg(1'b0, 4'd5);
		write_reg(1'b1, 4'd4);
		quiet = 1'b1;
		random_phase(6);
		quiet = 1'b0;
		write_reg(1'b0, 4'd2);
		write_reg(1'b1, 4'd4);
		random_phase(6);

		$display("Run: %0d items accepted, %0d results checked", n_items, n_results);
		$display("Run: %0d overflow drops, %0d converged passes seen", n_overflow, n_conv);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
